FILE: hw/rtl/route_table_longest_prefix_top_macros.svh
// Assertion macros for the route table checker
`ifndef ROUTE_TABLE_LONGEST_PREFIX_TOP_MACROS_SVH
`define ROUTE_TABLE_LONGEST_PREFIX_TOP_MACROS_SVH
// a implies b in the next cycle
`define RTLP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
// a implies b in the same cycle
`define RTLP_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/rtlp_pkg.sv
package rtlp_pkg;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ENTRY_W = 105;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD_STATIC = 3'd1;
  localparam logic [2:0] OP_ADD_CONN = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_CLR_STATIC = 3'd4;
  localparam logic [2:0] OP_CLR_CONN = 3'd5;
  localparam logic [2:0] OP_CLR_ALL = 3'd6;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_MATCH = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_CONN_REFUSED = 3'd4;
  localparam logic [2:0] ST_SKIPPED = 3'd5;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0] itf;
    logic static_flag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRITE, S_DONE
  } state_t;
endpackage

FILE: hw/rtl/rtlp_ram.sv
module rtlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/route_table_longest_prefix_top.sv
// Route table with longest-prefix lookup, one transaction at a time.
// Add connected, clear all, the unused code, a bad delete index and an empty table skip the
//   walk; other operations walk the used entries, a delete walks from its index to the end,
//   and a duplicate add stops early.
// Handshake: busy stays high until done pulses; the next transaction is taken in the done
//   cycle. The receiver cannot stall.
// Reset (rst, synchronous) empties the table; the RAM is not cleared.
module route_table_longest_prefix_top #(
  parameter int TABLE_DEPTH = rtlp_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [31:0] address,
  input  logic [31:0] netmask,
  input  logic [31:0] gateway,
  input  logic [7:0]  interface_number,
  input  logic [5:0]  entry_index,
  output logic        done,
  output logic [2:0]  status,
  output logic        found,
  output logic [31:0] route_dest,
  output logic [31:0] route_mask,
  output logic [31:0] route_gateway,
  output logic [7:0]  route_interface,
  output logic        route_static,
  output logic [5:0]  match_position,
  output logic [6:0]  entry_count
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  rtlp_pkg::state_t state, state_next;

  // captured transaction
  logic [2:0]  op;
  logic [31:0] addr, msk, gw;
  logic [7:0]  itf;
  logic [5:0]  idx;

  logic [CW-1:0] count;     // used entries
  logic [CW-1:0] rd_ptr;    // next entry to read
  logic [CW-1:0] wr_ptr;    // compaction / shift write pointer
  logic          rd_valid;  // RAM data belongs to entry rd_ptr-1
  logic [CW-1:0] rd_pos;
  logic          hit, dup;
  logic [5:0]    top_len;
  logic [AW-1:0] best_pos;
  rtlp_pkg::entry_t best;
  logic [2:0]    res_status;
  logic          deleting;  // delete index seen static, shifting

  logic          we;
  logic [AW-1:0] waddr, raddr;
  rtlp_pkg::entry_t wdata, rdata;

  rtlp_ram #(.WIDTH(rtlp_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = rd_ptr[AW-1:0];
  assign busy = (state != rtlp_pkg::S_IDLE);

  logic scan_end;
  assign scan_end = (rd_ptr >= count) && !rd_valid;

  // delete aimed at or beyond the used entries
  logic bad_index;
  assign bad_index = (operation == rtlp_pkg::OP_DELETE) && (CW'(entry_index) >= count);

  // delete target read back as a connected entry: stop the walk
  logic refuse;
  assign refuse = rd_valid && (op == rtlp_pkg::OP_DELETE) && !deleting && !rdata.static_flag;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rtlp_pkg::S_IDLE: if (start) state_next = rtlp_pkg::S_SCAN;
      rtlp_pkg::S_SCAN: if (scan_end || (op == rtlp_pkg::OP_ADD_STATIC && dup))
        state_next = rtlp_pkg::S_WRITE;
      rtlp_pkg::S_WRITE: state_next = rtlp_pkg::S_DONE;
      rtlp_pkg::S_DONE: state_next = rtlp_pkg::S_IDLE;
      default: state_next = rtlp_pkg::S_IDLE;
    endcase
  end

  logic cur_match, cur_dup, keep;
  logic [5:0] cur_len;
  always_comb begin
    cur_match = (addr & rdata.mask) == rdata.dest;
    cur_len = 6'($countones(rdata.mask));
    cur_dup = rdata.dest == addr && rdata.mask == msk && rdata.gateway == gw &&
              rdata.itf == itf;
    keep = 1'b0;
    unique case (op)
      rtlp_pkg::OP_CLR_STATIC: keep = !rdata.static_flag;
      rtlp_pkg::OP_CLR_CONN:   keep = rdata.static_flag;
      rtlp_pkg::OP_DELETE:     keep = deleting && (rd_pos != CW'(idx));
      default:                 keep = 1'b0;
    endcase
  end

  // RAM write: compaction in the scan, appends in the write state
  always_comb begin
    we = 1'b0;
    waddr = wr_ptr[AW-1:0];
    wdata = rdata;
    if (state == rtlp_pkg::S_SCAN && rd_valid && keep) begin
      we = 1'b1;
    end else if (state == rtlp_pkg::S_WRITE && count < CW'(TABLE_DEPTH)) begin
      waddr = count[AW-1:0];
      if (op == rtlp_pkg::OP_ADD_STATIC && !dup) begin
        we = 1'b1;
        wdata = '{dest: addr, mask: msk, gateway: gw, itf: itf, static_flag: 1'b1};
      end else if (op == rtlp_pkg::OP_ADD_CONN && addr != '0 && msk != '0) begin
        we = 1'b1;
        wdata = '{dest: addr & msk, mask: msk, gateway: '0, itf: itf, static_flag: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtlp_pkg::S_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        rtlp_pkg::S_IDLE: begin
          if (start) begin
            op <= operation; addr <= address; msk <= netmask; gw <= gateway;
            itf <= interface_number; idx <= entry_index;
            hit <= 1'b0; dup <= 1'b0; top_len <= '0; best_pos <= '0;
            rd_valid <= 1'b0;
            deleting <= 1'b0;
            res_status <= bad_index ? rtlp_pkg::ST_BAD_INDEX : rtlp_pkg::ST_OK;
            // delete starts the walk and the shift at the index; others at zero
            wr_ptr <= (operation == rtlp_pkg::OP_DELETE) ? CW'(entry_index) : '0;
            // operations with no walk and a bad index start at the end, so the scan reads no entry
            if (operation == rtlp_pkg::OP_ADD_CONN || operation == rtlp_pkg::OP_CLR_ALL ||
                operation == rtlp_pkg::OP_UNUSED || bad_index) begin
              rd_ptr <= count;
            end else if (operation == rtlp_pkg::OP_DELETE) begin
              rd_ptr <= CW'(entry_index);
            end else begin
              rd_ptr <= '0;
            end
          end
        end
        rtlp_pkg::S_SCAN: begin
          if (refuse) begin
            res_status <= rtlp_pkg::ST_CONN_REFUSED;
            rd_ptr <= count;
            rd_valid <= 1'b0;
          end else if (rd_ptr < count && !(op == rtlp_pkg::OP_ADD_STATIC && dup)) begin
            rd_ptr <= rd_ptr + 1'b1;
            rd_pos <= rd_ptr;
            rd_valid <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
          end
          if (rd_valid) begin
            unique case (op)
              rtlp_pkg::OP_LOOKUP: if (cur_match && (!hit || cur_len > top_len)) begin
                hit <= 1'b1; top_len <= cur_len; best_pos <= rd_pos[AW-1:0];
                best <= rdata;
              end
              rtlp_pkg::OP_ADD_STATIC: if (cur_dup) dup <= 1'b1;
              rtlp_pkg::OP_DELETE: begin
                if (!deleting) begin
                  // first read is the target entry
                  if (rdata.static_flag) deleting <= 1'b1;
                end else begin
                  wr_ptr <= wr_ptr + 1'b1;
                end
              end
              default: if (keep) wr_ptr <= wr_ptr + 1'b1;
            endcase
          end
        end
        rtlp_pkg::S_WRITE: begin
          unique case (op)
            rtlp_pkg::OP_LOOKUP: if (!hit) res_status <= rtlp_pkg::ST_NO_MATCH;
            rtlp_pkg::OP_ADD_STATIC: if (!dup) begin
              if (count >= CW'(TABLE_DEPTH)) res_status <= rtlp_pkg::ST_FULL;
              else count <= count + 1'b1;
            end
            rtlp_pkg::OP_ADD_CONN: begin
              if (addr == '0 || msk == '0) res_status <= rtlp_pkg::ST_SKIPPED;
              else if (count >= CW'(TABLE_DEPTH)) res_status <= rtlp_pkg::ST_FULL;
              else count <= count + 1'b1;
            end
            rtlp_pkg::OP_DELETE: if (deleting) count <= count - 1'b1;
            rtlp_pkg::OP_CLR_STATIC, rtlp_pkg::OP_CLR_CONN: count <= wr_ptr;
            rtlp_pkg::OP_CLR_ALL: count <= '0;
            default: res_status <= rtlp_pkg::ST_SKIPPED;
          endcase
        end
        rtlp_pkg::S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  // result fields, valid while done pulses
  logic show;
  assign show = (op == rtlp_pkg::OP_LOOKUP) && hit;
  always_ff @(posedge clk) begin
    if (state == rtlp_pkg::S_DONE) begin
      status <= res_status;
      found <= show;
      route_dest <= show ? best.dest : '0;
      route_mask <= show ? best.mask : '0;
      route_gateway <= show ? best.gateway : '0;
      route_interface <= show ? best.itf : '0;
      route_static <= show ? best.static_flag : 1'b0;
      match_position <= show ? 6'(best_pos) : '0;
      entry_count <= 7'(count);
    end
  end
endmodule

FILE: hw/rtl/rtlp_checker.sv
`include "route_table_longest_prefix_top_macros.svh"
module rtlp_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       found,
  input logic [2:0] status,
  input logic [6:0] entry_count
);
  `RTLP_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy)
  `RTLP_ASSERT_NOW(a_done_single, clk, rst, done, $past(busy))
  `RTLP_ASSERT_NOW(a_found_ok, clk, rst, done && found, status == rtlp_pkg::ST_OK)
  `RTLP_ASSERT_NOW(a_count_range, clk, rst, done, entry_count <= 7'(rtlp_pkg::TABLE_DEPTH_DEF))
endmodule

bind route_table_longest_prefix_top rtlp_checker u_rtlp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .found(found), .status(status), .entry_count(entry_count)
);

FILE: sim/route_table_longest_prefix_top_tb.sv
module route_table_longest_prefix_top_tb;
  import rtlp_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  operation = OP_LOOKUP;
  logic [31:0] address = '0;
  logic [31:0] netmask = '0;
  logic [31:0] gateway = '0;
  logic [7:0]  interface_number = '0;
  logic [5:0]  entry_index = '0;
  logic        done;
  logic [2:0]  status;
  logic        found;
  logic [31:0] route_dest;
  logic [31:0] route_mask;
  logic [31:0] route_gateway;
  logic [7:0]  route_interface;
  logic        route_static;
  logic [5:0]  match_position;
  logic [6:0]  entry_count;

  route_table_longest_prefix_top u_top (.*);

  always #5 clk = ~clk;

  // One expected response of the block.
  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0]  itf;
    logic        static_flag;
    logic [5:0]  pos;
    logic [6:0]  count;
  } reply_t;

  // Shadow copy of the route table.
  entry_t      shadow_table [DEPTH];
  int          shadow_count;
  reply_t      pending_replies [$];
  int          error_count;
  int          sent_count;
  int          reply_count;
  int          lookup_hits;
  int          full_seen;

  // Track recent routes so lookups hit real entries.
  logic [31:0] recent_addr [$];

  function automatic int mask_ones(logic [31:0] m);
    int n;
    n = 0;
    for (int b = 0; b < 32; b++) n += m[b];
    return n;
  endfunction

  function automatic logic [31:0] mask_of(int len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  // Apply one transaction to the shadow table and return the expected reply.
  function automatic reply_t route_predict(logic [2:0] op, logic [31:0] a, logic [31:0] m,
                                           logic [31:0] g, logic [7:0] itf, logic [5:0] idx);
    reply_t r;
    int     best;
    int     top_len;
    int     keep;
    bit     dup;
    r = '0;
    case (op)
      OP_LOOKUP: begin
        best = -1;
        top_len = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if ((a & shadow_table[i].mask) == shadow_table[i].dest) begin
            if (best < 0 || mask_ones(shadow_table[i].mask) > top_len) begin
              best = i;
              top_len = mask_ones(shadow_table[i].mask);
            end
          end
        end
        if (best >= 0) begin
          r.found = 1'b1;
          r.dest = shadow_table[best].dest;
          r.mask = shadow_table[best].mask;
          r.gateway = shadow_table[best].gateway;
          r.itf = shadow_table[best].itf;
          r.static_flag = shadow_table[best].static_flag;
          r.pos = best[5:0];
        end else begin
          r.status = ST_NO_MATCH;
        end
      end
      OP_ADD_STATIC: begin
        dup = 0;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_table[i].dest == a && shadow_table[i].mask == m &&
              shadow_table[i].gateway == g && shadow_table[i].itf == itf) dup = 1;
        if (!dup) begin
          if (shadow_count >= DEPTH) r.status = ST_FULL;
          else begin
            shadow_table[shadow_count] = '{a, m, g, itf, 1'b1};
            shadow_count++;
          end
        end
      end
      OP_ADD_CONN: begin
        if (a == 0 || m == 0) r.status = ST_SKIPPED;
        else if (shadow_count >= DEPTH) r.status = ST_FULL;
        else begin
          shadow_table[shadow_count] = '{a & m, m, 32'h0, itf, 1'b0};
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (idx >= shadow_count) r.status = ST_BAD_INDEX;
        else if (!shadow_table[idx].static_flag) r.status = ST_CONN_REFUSED;
        else begin
          for (int i = idx; i + 1 < shadow_count; i++) shadow_table[i] = shadow_table[i + 1];
          shadow_count--;
        end
      end
      OP_CLR_STATIC, OP_CLR_CONN: begin
        keep = 0;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_table[i].static_flag == (op == OP_CLR_CONN)) begin
            shadow_table[keep] = shadow_table[i];
            keep++;
          end
        shadow_count = keep;
      end
      OP_CLR_ALL: shadow_count = 0;
      default: r.status = ST_SKIPPED;
    endcase
    r.count = shadow_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch on %s: got %0h, want %0h (reply %0d)", what, got, want, reply_count);
  endtask

  // Drive one transaction at the falling edge and hold until it is taken.
  task automatic send_route_op(logic [2:0] op, logic [31:0] a, logic [31:0] m,
                               logic [31:0] g, logic [7:0] itf, logic [5:0] idx);
    @(negedge clk);
    operation <= op;
    address <= a;
    netmask <= m;
    gateway <= g;
    interface_number <= itf;
    entry_index <= idx;
    start <= 1'b1;
    // Wait for the edge that accepts the transaction.
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_replies.push_back(route_predict(op, a, m, g, itf, idx));
    sent_count++;
    if (a != 0 && (op == OP_ADD_STATIC || op == OP_ADD_CONN)) recent_addr.push_back(a);
    if (recent_addr.size() > 32) void'(recent_addr.pop_front());
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Random gap after a transaction: sometimes hold start low for a while.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    repeat (n) @(negedge clk);
  endtask

  // Sample every done strobe and compare with the oldest expectation.
  always @(posedge clk) begin
    reply_t w;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", {29'b0, status}, 32'h0);
      end else begin
        w = pending_replies.pop_front();
        if (status != w.status) report_mismatch("status", 32'(status), 32'(w.status));
        if (found != w.found) report_mismatch("found", 32'(found), 32'(w.found));
        if (route_dest != w.dest) report_mismatch("route_dest", route_dest, w.dest);
        if (route_mask != w.mask) report_mismatch("route_mask", route_mask, w.mask);
        if (route_gateway != w.gateway)
          report_mismatch("route_gateway", route_gateway, w.gateway);
        if (route_interface != w.itf)
          report_mismatch("route_interface", 32'(route_interface), 32'(w.itf));
        if (route_static != w.static_flag)
          report_mismatch("route_static", 32'(route_static), 32'(w.static_flag));
        if (match_position != w.pos)
          report_mismatch("match_position", 32'(match_position), 32'(w.pos));
        if (entry_count != w.count)
          report_mismatch("entry_count", 32'(entry_count), 32'(w.count));
        if (w.found) lookup_hits++;
        if (w.status == ST_FULL) full_seen++;
      end
      reply_count++;
    end
  end

  // Directed corners: extremes, every operation code and each special case.
  task automatic test_directed();
    send_route_op(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0);             // empty table
    send_route_op(OP_DELETE, 0, 0, 0, 0, 6'd0);                       // bad index
    send_route_op(OP_ADD_STATIC, 32'h0, 32'h0, 32'hFFFF_FFFF, 8'hFF, 0); // default route
    send_route_op(OP_ADD_STATIC, 32'h0, 32'h0, 32'hFFFF_FFFF, 8'hFF, 0); // duplicate
    send_route_op(OP_ADD_STATIC, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 8'h01, 0);
    send_route_op(OP_ADD_STATIC, 32'h0A01_0000, 32'hFFFF_0000, 32'h0, 8'h02, 0);
    send_route_op(OP_ADD_CONN, 32'h0A01_0203, 32'hFFFF_0000, 32'h1234, 8'h03, 0); // tie
    send_route_op(OP_ADD_CONN, 32'h0, 32'hFFFF_FF00, 0, 8'h04, 0);    // zero address
    send_route_op(OP_ADD_CONN, 32'hC0A8_0001, 32'h0, 0, 8'h04, 0);    // zero mask
    send_route_op(OP_ADD_CONN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 8'h80, 0);
    send_route_op(OP_LOOKUP, 32'h0A01_0505, 0, 0, 0, 0);               // earliest wins tie
    send_route_op(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_route_op(OP_LOOKUP, 32'h0B00_0000, 0, 0, 0, 0);
    send_route_op(OP_DELETE, 0, 0, 0, 0, 6'd3);                        // connected refused
    send_route_op(OP_DELETE, 0, 0, 0, 0, 6'd63);
    send_route_op(OP_DELETE, 0, 0, 0, 0, 6'd1);                        // shift down
    send_route_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 6'h3F); // unused code
    send_route_op(OP_CLR_STATIC, 0, 0, 0, 0, 0);
    send_route_op(OP_LOOKUP, 32'h0A01_0000, 0, 0, 0, 0);
    send_route_op(OP_ADD_STATIC, 32'h0A00_0000, 32'hFF00_0000, 32'h5, 8'h9, 0);
    send_route_op(OP_CLR_CONN, 0, 0, 0, 0, 0);
    send_route_op(OP_CLR_ALL, 0, 0, 0, 0, 0);
  endtask

  // Fill past the depth to reach the full-table cases, then clear.
  task automatic test_full_table();
    for (int i = 0; i < DEPTH + 2; i++)
      send_route_op(i[0] ? OP_ADD_CONN : OP_ADD_STATIC, $urandom() | 32'h1,
                    mask_of($urandom_range(1, 32)), $urandom(), 8'($urandom()), 0);
    send_route_op(OP_ADD_STATIC, 32'h1, 32'h1, 32'h1, 8'h1, 0);
    send_route_op(OP_LOOKUP, $urandom(), 0, 0, 0, 0);
    send_route_op(OP_DELETE, 0, 0, 0, 0, 6'd63);
    send_route_op(OP_CLR_ALL, 0, 0, 0, 0, 0);
  endtask

  // Mostly meaningful traffic: prefixes from a small pool so lookups hit.
  task automatic test_random_traffic(int n_items);
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] m;
    int          pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      m = ($urandom_range(0, 9) == 0) ? $urandom() : mask_of($urandom_range(0, 32));
      if (recent_addr.size() > 0 && $urandom_range(0, 1))
        a = recent_addr[$urandom_range(0, recent_addr.size() - 1)] ^ ($urandom() >> 20);
      else
        a = $urandom();
      if (pick < 40) op = OP_LOOKUP;
      else if (pick < 62) op = OP_ADD_STATIC;
      else if (pick < 80) op = OP_ADD_CONN;
      else if (pick < 92) op = OP_DELETE;
      else if (pick < 95) op = OP_CLR_STATIC;
      else if (pick < 97) op = OP_CLR_CONN;
      else if (pick < 99) op = OP_CLR_ALL;
      else op = OP_UNUSED;
      // Static adds store the destination already masked most of the time.
      if (op == OP_ADD_STATIC && $urandom_range(0, 3) != 0) a = a & m;
      send_route_op(op, a, m, ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom(),
                    8'($urandom()), (shadow_count > 0 && $urandom_range(0, 3) != 0) ?
                    6'($urandom_range(0, shadow_count - 1)) : 6'($urandom()));
      idle_gap();
    end
  endtask

  initial begin
    error_count = 0;
    sent_count = 0;
    reply_count = 0;
    lookup_hits = 0;
    full_seen = 0;
    shadow_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random_traffic(1500);
    // Drain: every transaction answers, then allow a full walk more.
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    $display("sent %0d transactions, %0d replies checked", sent_count, reply_count);
    $display("lookup hits %0d, table-full replies %0d", lookup_hits, full_seen);
    if (error_count == 0 && pending_replies.size() == 0)
      $display("route_table_longest_prefix_top test passed");
    else
      $display("route_table_longest_prefix_top test failed");
    $finish;
  end

  initial begin
    #10000000;
    $display("route_table_longest_prefix_top test failed");
    $finish;
  end
endmodule

FILE: route_table_longest_prefix_top.f
+incdir+hw/rtl
hw/rtl/rtlp_pkg.sv
hw/rtl/rtlp_ram.sv
hw/rtl/route_table_longest_prefix_top.sv
hw/rtl/rtlp_checker.sv
sim/route_table_longest_prefix_top_tb.sv
